FILE: design/umbrella_laplacian_smooth_step_top_macros.svh
// Assertion macros for the umbrella smoothing step block.
// Used by the top level; expects clk and arst_n in the including scope.
`ifndef UMBRELLA_LAPLACIAN_SMOOTH_STEP_TOP_MACROS_SVH
`define UMBRELLA_LAPLACIAN_SMOOTH_STEP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ULSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define ULSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ulss_pkg.sv
// Package for the umbrella smoothing step block: widths, item types and control structs.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ulss_pkg;

	// Field and datapath widths.
	localparam int COORD_W     = 32;
	localparam int GAIN_W      = 16;
	localparam int GAIN_FRAC   = 14;
	localparam int SUM_W       = 48;
	localparam int CNT_W       = 8;
	localparam int MAX_CORNERS = 192;
	localparam int NUM_AXES    = 3;
	localparam int AXIS_W      = 2;

	// Triangle count is corners / 3, done as a multiply by 171 / 512.
	localparam int TRI_RECIP   = 171;
	localparam int TRI_SHIFT   = 9;
	localparam int TRI_PROD_W  = 2 * CNT_W;
	localparam int TRI_W       = TRI_PROD_W - TRI_SHIFT;
	localparam int DVSR_W      = TRI_W + 1;
	localparam int TRI_MAX     = MAX_CORNERS / 3;

	// Divider, multiplier and final add widths.
	localparam int DIV_STEPS   = SUM_W;
	localparam int DCNT_W      = $clog2(DIV_STEPS);
	localparam int HALF_W      = SUM_W / 2;
	localparam int PART_W      = HALF_W + GAIN_W;
	localparam int PROD_W      = SUM_W + GAIN_W;
	localparam int FIN_W       = SUM_W + 2;

	// Reset value of the gain register (0.5 in Q1.14).
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(8192);

	typedef logic [NUM_AXES-1:0][COORD_W-1:0] pos3_t;
	typedef logic [NUM_AXES-1:0][SUM_W-1:0]   sum3_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic signed [COORD_W-1:0] vertex_z;
		logic signed [COORD_W-1:0] corner_x;
		logic signed [COORD_W-1:0] corner_y;
		logic signed [COORD_W-1:0] corner_z;
		logic                      last_corner;
	} in_item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] new_x;
		logic signed [COORD_W-1:0] new_y;
		logic signed [COORD_W-1:0] new_z;
		logic                      no_triangles;
	} out_item_t;

	// Accumulator control from the sequencer.
	typedef struct packed {
		logic              en;
		logic              clear;
		logic [AXIS_W-1:0] axis;
	} acc_ctl_t;

	// Divider status back to the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

FILE: design/ulss_acc.sv
// Corner accumulator: three saturating 48-bit sums sharing one adder, plus the corner count.
// Depends on ulss_pkg.
`timescale 1ns / 1ps

module ulss_acc (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ulss_pkg::acc_ctl_t          ctl,
	input  ulss_pkg::pos3_t             vertex,
	input  ulss_pkg::pos3_t             corner,
	output ulss_pkg::sum3_t             sums,
	output logic [ulss_pkg::TRI_W-1:0]  tri_cnt
);

	localparam int DIFF_W = ulss_pkg::COORD_W + 1;
	localparam int ACC_W  = ulss_pkg::SUM_W + 1;

	ulss_pkg::sum3_t                     sum_q;
	logic [ulss_pkg::CNT_W-1:0]          count_q;
	logic [ulss_pkg::COORD_W-1:0]        crn;
	logic [ulss_pkg::COORD_W-1:0]        vtx;
	logic [ulss_pkg::SUM_W-1:0]          cur;
	logic [DIFF_W-1:0]                   diff;
	logic [ACC_W-1:0]                    total;
	logic [ulss_pkg::SUM_W-1:0]          sat;
	logic [ulss_pkg::TRI_PROD_W-1:0]     tri_prod;

	// Shared adder: corner minus vertex added to the selected axis sum.
	always_comb begin
		crn   = corner[ctl.axis];
		vtx   = vertex[ctl.axis];
		cur   = sum_q[ctl.axis];
		diff  = {crn[ulss_pkg::COORD_W-1], crn} - {vtx[ulss_pkg::COORD_W-1], vtx};
		total = {cur[ulss_pkg::SUM_W-1], cur}
			+ {{(ACC_W-DIFF_W){diff[DIFF_W-1]}}, diff};
		if (total[ACC_W-1] != total[ACC_W-2]) begin
			sat = {total[ACC_W-1], {(ulss_pkg::SUM_W-1){~total[ACC_W-1]}}};
		end else begin
			sat = total[ulss_pkg::SUM_W-1:0];
		end
	end

	// Sums and count; the count steps once per item, on the first axis.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (ctl.clear) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (ctl.en) begin
			sum_q[ctl.axis] <= sat;
			if ((ctl.axis == '0) && (count_q < ulss_pkg::CNT_W'(ulss_pkg::MAX_CORNERS))) begin
				count_q <= count_q + ulss_pkg::CNT_W'(1);
			end
		end
	end

	// Whole triangles: count / 3 by reciprocal multiply, exact over the 8-bit range.
	always_comb begin
		tri_prod = ulss_pkg::TRI_PROD_W'(count_q) * ulss_pkg::TRI_PROD_W'(ulss_pkg::TRI_RECIP);
		tri_cnt  = tri_prod[ulss_pkg::TRI_PROD_W-1:ulss_pkg::TRI_SHIFT];
	end

	assign sums = sum_q;

endmodule

FILE: design/ulss_div.sv
// Restoring divider, one quotient bit per cycle, shared by the three axes.
// Depends on ulss_pkg.
`timescale 1ns / 1ps

module ulss_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [ulss_pkg::SUM_W-1:0]  dividend,
	input  logic [ulss_pkg::DVSR_W-1:0] divisor,
	output ulss_pkg::div_sts_t          sts,
	output logic [ulss_pkg::SUM_W-1:0]  quotient
);

	logic [ulss_pkg::DVSR_W-1:0] rem_q;
	logic [ulss_pkg::DVSR_W-1:0] dvsr_q;
	logic [ulss_pkg::SUM_W-1:0]  quo_q;
	logic [ulss_pkg::DCNT_W-1:0] cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic [ulss_pkg::DVSR_W:0]   shifted;
	logic [ulss_pkg::DVSR_W:0]   trial;
	logic                        ge;

	// One step: shift in the next dividend bit and try a subtract.
	always_comb begin
		shifted = {rem_q, quo_q[ulss_pkg::SUM_W-1]};
		trial   = shifted - {1'b0, dvsr_q};
		ge      = (shifted >= {1'b0, dvsr_q});
	end

	// Control: a run of SUM_W steps, then a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + ulss_pkg::DCNT_W'(1);
				if (cnt_q == ulss_pkg::DCNT_W'(ulss_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits as it drains.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dvsr_q <= divisor;
			quo_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? trial[ulss_pkg::DVSR_W-1:0] : shifted[ulss_pkg::DVSR_W-1:0];
			quo_q <= {quo_q[ulss_pkg::SUM_W-2:0], ge};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = quo_q;

endmodule

FILE: design/umbrella_laplacian_smooth_step_top.sv
// Top level of the umbrella smoothing step: sequencer, gain register, multiply and round.
// Depends on ulss_pkg, ulss_acc, ulss_div and the assertion macro header.
//
// Usage:
// Each input item on in_valid/in_ready carries the vertex and one triangle corner.
// Items with last_corner low only accumulate and give no result. An item with
// last_corner high closes the vertex and gives one result on out_valid/out_ready.
// The gain register is written on cfg_valid/cfg_ready (always ready); the user must
// write it only while idle, as the block does not enforce this. A corner item passes
// once per axis through the shared accumulator. A closing item then runs, one axis
// after another, through the bit-serial divider (a start, a step per quotient bit and a
// hand-off), a 24x16 multiply of the low then the high half, a rounding step and a
// saturating add, then loads the output register; with no whole triangle it goes
// straight to the output register. in_ready is high only between items.
// The result sits in an output register; a stalled receiver does not stop the
// next vertex from accumulating, only the next closing item waits for the slot.
// Reset clears the sums, the corner count and the output valid, and sets the
// gain to 0.5.
`timescale 1ns / 1ps
`include "umbrella_laplacian_smooth_step_top_macros.svh"

module umbrella_laplacian_smooth_step_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ulss_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ulss_pkg::out_item_t                 out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic signed [ulss_pkg::GAIN_W-1:0]  cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC,
		S_DIV_GO,
		S_DIV_WAIT,
		S_MUL_LO,
		S_MUL_HI,
		S_RND,
		S_FIN,
		S_DONE
	} state_t;

	localparam logic [ulss_pkg::AXIS_W-1:0] LAST_AXIS = ulss_pkg::AXIS_W'(ulss_pkg::NUM_AXES - 1);
	localparam logic [ulss_pkg::PROD_W-1:0] ROUND_HALF =
		ulss_pkg::PROD_W'(1) << (ulss_pkg::GAIN_FRAC - 1);
	localparam int UPPER_W = ulss_pkg::FIN_W - ulss_pkg::COORD_W + 1;

	state_t                             state_q;
	logic [ulss_pkg::AXIS_W-1:0]        axis_q;
	logic                               out_valid_q;
	ulss_pkg::out_item_t                out_q;
	logic [ulss_pkg::GAIN_W-1:0]        gain_q;

	ulss_pkg::in_item_t                 item_q;
	ulss_pkg::pos3_t                    res_q;
	logic                               no_tri_q;
	logic                               neg_q;
	logic [ulss_pkg::SUM_W-1:0]         mag_q;
	logic [ulss_pkg::PART_W-1:0]        prod_lo_q;
	logic [ulss_pkg::PART_W-1:0]        prod_hi_q;
	logic [ulss_pkg::SUM_W-1:0]         qmag_q;

	ulss_pkg::acc_ctl_t                 acc_ctl;
	ulss_pkg::pos3_t                    vtx_a;
	ulss_pkg::pos3_t                    crn_a;
	ulss_pkg::sum3_t                    sums;
	logic [ulss_pkg::TRI_W-1:0]         tri_cnt;
	ulss_pkg::div_sts_t                 div_sts;
	logic                               div_start;
	logic [ulss_pkg::SUM_W-1:0]         dividend;
	logic [ulss_pkg::SUM_W-1:0]         quotient;

	logic [ulss_pkg::SUM_W-1:0]         sum_sel;
	logic [ulss_pkg::SUM_W-1:0]         sum_mag;
	logic [ulss_pkg::GAIN_W-1:0]        gain_mag;
	logic [ulss_pkg::HALF_W-1:0]        mul_a;
	logic [ulss_pkg::PART_W-1:0]        mul_p;
	logic [ulss_pkg::PROD_W-1:0]        rnd_sum;
	logic [ulss_pkg::COORD_W-1:0]       pos;
	logic [ulss_pkg::FIN_W-1:0]         pos_ext;
	logic [ulss_pkg::FIN_W-1:0]         q_ext;
	logic [ulss_pkg::FIN_W-1:0]         fin_sum;
	logic [UPPER_W-1:0]                 upper;
	logic [ulss_pkg::COORD_W-1:0]       fin_val;
	logic                               out_free;

	// Per-axis views of the held item; index 0 is x.
	assign vtx_a = {item_q.vertex_z, item_q.vertex_y, item_q.vertex_x};
	assign crn_a = {item_q.corner_z, item_q.corner_y, item_q.corner_x};

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Accumulator control.
	always_comb begin
		acc_ctl.en    = (state_q == S_ACC);
		acc_ctl.clear = (state_q == S_DONE) && out_free;
		acc_ctl.axis  = axis_q;
	end

	ulss_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (acc_ctl),
		.vertex  (vtx_a),
		.corner  (crn_a),
		.sums    (sums),
		.tri_cnt (tri_cnt)
	);

	// Mean rounding: |sum| + triangles, divided by twice the triangles.
	always_comb begin
		sum_sel   = sums[axis_q];
		sum_mag   = sum_sel[ulss_pkg::SUM_W-1] ? (~sum_sel + ulss_pkg::SUM_W'(1)) : sum_sel;
		dividend  = sum_mag + ulss_pkg::SUM_W'(tri_cnt);
		div_start = (state_q == S_DIV_GO);
	end

	ulss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  ({tri_cnt, 1'b0}),
		.sts      (div_sts),
		.quotient (quotient)
	);

	// One 24x16 multiplier used twice per axis on the magnitudes.
	always_comb begin
		gain_mag = gain_q[ulss_pkg::GAIN_W-1] ? (~gain_q + ulss_pkg::GAIN_W'(1)) : gain_q;
		mul_a    = (state_q == S_MUL_HI) ? mag_q[ulss_pkg::SUM_W-1:ulss_pkg::HALF_W]
			: mag_q[ulss_pkg::HALF_W-1:0];
		mul_p    = ulss_pkg::PART_W'(mul_a) * ulss_pkg::PART_W'(gain_mag);
	end

	// Recombine the partial products and round half away from zero on the magnitude.
	assign rnd_sum = ulss_pkg::PROD_W'(prod_lo_q)
		+ {prod_hi_q, {ulss_pkg::HALF_W{1'b0}}} + ROUND_HALF;

	// Vertex plus signed scaled mean, saturated to 32 bits.
	always_comb begin
		pos     = vtx_a[axis_q];
		pos_ext = {{(ulss_pkg::FIN_W-ulss_pkg::COORD_W){pos[ulss_pkg::COORD_W-1]}}, pos};
		q_ext   = {{(ulss_pkg::FIN_W-ulss_pkg::SUM_W){1'b0}}, qmag_q};
		fin_sum = neg_q ? (pos_ext - q_ext) : (pos_ext + q_ext);
		upper   = fin_sum[ulss_pkg::FIN_W-1:ulss_pkg::COORD_W-1];
		if ((upper == '0) || (upper == '1)) begin
			fin_val = fin_sum[ulss_pkg::COORD_W-1:0];
		end else begin
			fin_val = {fin_sum[ulss_pkg::FIN_W-1],
				{(ulss_pkg::COORD_W-1){~fin_sum[ulss_pkg::FIN_W-1]}}};
		end
	end

	// Gain register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= ulss_pkg::GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gain_q <= cfg_data;
		end
	end

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			// The output slot fills from a finished vertex or empties when taken.
			if ((state_q == S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						axis_q  <= '0;
						state_q <= S_ACC;
					end
				end
				S_ACC: begin
					if (axis_q == LAST_AXIS) begin
						axis_q <= '0;
						if (!item_q.last_corner) begin
							state_q <= S_IDLE;
						end else if (tri_cnt == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV_GO;
						end
					end else begin
						axis_q <= axis_q + ulss_pkg::AXIS_W'(1);
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_sts.done) begin
						state_q <= S_MUL_LO;
					end
				end
				S_MUL_LO: begin
					state_q <= S_MUL_HI;
				end
				S_MUL_HI: begin
					state_q <= S_RND;
				end
				S_RND: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (axis_q == LAST_AXIS) begin
						axis_q  <= '0;
						state_q <= S_DONE;
					end else begin
						axis_q  <= axis_q + ulss_pkg::AXIS_W'(1);
						state_q <= S_DIV_GO;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_q.new_x        <= res_q[0];
						out_q.new_y        <= res_q[1];
						out_q.new_z        <= res_q[2];
						out_q.no_triangles <= no_tri_q;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, loaded by state.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			item_q <= in_data;
		end
		if (state_q == S_ACC && axis_q == LAST_AXIS) begin
			no_tri_q <= (tri_cnt == '0);
			res_q    <= vtx_a;
		end
		if (state_q == S_DIV_GO) begin
			neg_q <= sum_sel[ulss_pkg::SUM_W-1] ^ gain_q[ulss_pkg::GAIN_W-1];
		end
		if (state_q == S_DIV_WAIT && div_sts.done) begin
			mag_q <= quotient;
		end
		if (state_q == S_MUL_LO) begin
			prod_lo_q <= mul_p;
		end
		if (state_q == S_MUL_HI) begin
			prod_hi_q <= mul_p;
		end
		if (state_q == S_RND) begin
			qmag_q <= rnd_sum[ulss_pkg::GAIN_FRAC +: ulss_pkg::SUM_W];
		end
		if (state_q == S_FIN) begin
			res_q[axis_q] <= fin_val;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The block takes one item at a time.
	`ULSS_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted while busy")
	// The divider is started only when idle and finishes only while awaited.
	`ULSS_ASSERT_NOW(a_div_start, div_start, !div_sts.busy, "divider restarted while busy")
	`ULSS_ASSERT_NOW(a_div_done, div_sts.done, state_q == S_DIV_WAIT, "divider result unclaimed")
	// A finished vertex always lands in the output register.
	`ULSS_ASSERT_NEXT(a_result_out, (state_q == S_DONE) && out_free, out_valid, "result lost")
	// The triangle count stays within the corner limit.
	`ULSS_ASSERT_NOW(a_tri_range, 1'b1, tri_cnt <= ulss_pkg::TRI_W'(ulss_pkg::TRI_MAX), "count overrun")

endmodule

FILE: dv/tb_umbrella_laplacian_smooth_step_top.sv
// Self-checking testbench for the umbrella Laplacian smoothing step top level.
// Depends on ulss_pkg and the design; predicts each smoothed vertex and checks every result.
`timescale 1ns / 1ps

module tb_umbrella_laplacian_smooth_step_top;

	localparam logic signed [ulss_pkg::COORD_W-1:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [ulss_pkg::COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
	localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_LO = -SUM_HI - 1;
	localparam longint OUT_HI = 64'sh0000_0000_7FFF_FFFF;
	localparam longint OUT_LO = -OUT_HI - 1;
	// Settling time after the last result, as margin before any gain write.
	localparam int IDLE_CYCLES = 250;
	localparam int WATCHDOG_LIMIT = 5000;
	// Enough full-scale corners on one vertex to drive the corner count into saturation.
	localparam int SAT_CORNERS = 200;
	localparam int PHASE_ITEMS = 80;

	// Reference predictor for the smoothing step, with its own sums, count and gain.
	class smooth_scoreboard;
		logic signed [ulss_pkg::GAIN_W-1:0] gain;
		longint acc[ulss_pkg::NUM_AXES];
		int unsigned corners;
		ulss_pkg::out_item_t expected_q[$];
		int unsigned mismatches;
		int unsigned results_checked;
		int unsigned closes;
		int unsigned empty_closes;

		function new();
			gain = ulss_pkg::GAIN_RESET;
			foreach (acc[a])
				acc[a] = 0;
			corners = 0;
			mismatches = 0;
			results_checked = 0;
			closes = 0;
			empty_closes = 0;
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		// Division with round to nearest, ties away from zero.
		function longint div_nearest(longint v, longint unsigned d);
			longint unsigned mag;
			longint unsigned q;
			mag = (v < 0) ? longint'(-v) : longint'(v);
			q = (mag + d / 2) / d;
			return (v < 0) ? -longint'(q) : longint'(q);
		endfunction

		// Drop the Q1.14 fraction with round to nearest, ties away from zero.
		function longint drop_gain_frac(longint v);
			longint unsigned mag;
			longint unsigned q;
			mag = (v < 0) ? longint'(-v) : longint'(v);
			q = (mag + (64'd1 << (ulss_pkg::GAIN_FRAC - 1))) >> ulss_pkg::GAIN_FRAC;
			return (v < 0) ? -longint'(q) : longint'(q);
		endfunction

		function longint smoothed_axis(longint pos, longint sum, longint unsigned divisor);
			longint mean;
			mean = div_nearest(sum, divisor);
			return clamp(pos + drop_gain_frac(mean * longint'(gain)), OUT_LO, OUT_HI);
		endfunction

		// Accumulate one accepted corner; a closing item queues the smoothed vertex.
		function void note_corner(ulss_pkg::in_item_t it);
			longint vtx[ulss_pkg::NUM_AXES];
			longint cor[ulss_pkg::NUM_AXES];
			longint pos_new[ulss_pkg::NUM_AXES];
			int unsigned tri_count;
			ulss_pkg::out_item_t want;
			vtx = '{longint'(it.vertex_x), longint'(it.vertex_y), longint'(it.vertex_z)};
			cor = '{longint'(it.corner_x), longint'(it.corner_y), longint'(it.corner_z)};
			foreach (acc[a])
				acc[a] = clamp(acc[a] + (cor[a] - vtx[a]), SUM_LO, SUM_HI);
			if (corners < ulss_pkg::MAX_CORNERS)
				corners++;
			if (!it.last_corner)
				return;
			tri_count = corners / 3;
			closes++;
			if (tri_count == 0) begin
				pos_new = vtx;
				want.no_triangles = 1'b1;
				empty_closes++;
			end else begin
				foreach (pos_new[a])
					pos_new[a] = smoothed_axis(vtx[a], acc[a], 2 * tri_count);
				want.no_triangles = 1'b0;
			end
			want.new_x = ulss_pkg::COORD_W'(pos_new[0]);
			want.new_y = ulss_pkg::COORD_W'(pos_new[1]);
			want.new_z = ulss_pkg::COORD_W'(pos_new[2]);
			expected_q.insert(expected_q.size(), want);
			foreach (acc[a])
				acc[a] = 0;
			corners = 0;
		endfunction

		function void check_field(string name, logic [ulss_pkg::COORD_W-1:0] want,
				logic [ulss_pkg::COORD_W-1:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
					$signed(want), $signed(got));
			end
		endfunction

		// Compare one accepted result with the oldest pending vertex.
		function void check_result(ulss_pkg::out_item_t got);
			ulss_pkg::out_item_t want;
			results_checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual x=%0d y=%0d z=%0d flag=%0b",
					$time, got.new_x, got.new_y, got.new_z, got.no_triangles);
				return;
			end
			want = expected_q.pop_front();
			check_field("new_x", want.new_x, got.new_x);
			check_field("new_y", want.new_y, got.new_y);
			check_field("new_z", want.new_z, got.new_z);
			check_field("no_triangles", {31'b0, want.no_triangles}, {31'b0, got.no_triangles});
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	ulss_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	ulss_pkg::out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic signed [ulss_pkg::GAIN_W-1:0] cfg_data = '0;

	smooth_scoreboard sb;
	int unsigned items_sent = 0;
	int unsigned gain_writes = 0;
	int unsigned burst_left = 0;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;
	int unsigned quiet_cycles = 0;

	umbrella_laplacian_smooth_step_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Observe accepted items on all three channels.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.gain = cfg_data;
			if (in_valid && in_ready)
				sb.note_corner(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
		end
	end

	// Receiver back-pressure: random stalls, with quiet stretches free of new stalls.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ((cycle_count / 3000) % 4 != 3 && $urandom_range(0, 7) == 0)
				stall_left <= $urandom_range(1, 40);
		end
	end

	// Watchdog on cycles without any accepted item.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item accepted for %0d cycles", $time, quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic ulss_pkg::in_item_t make_item(logic signed [ulss_pkg::COORD_W-1:0] vx,
			logic signed [ulss_pkg::COORD_W-1:0] vy, logic signed [ulss_pkg::COORD_W-1:0] vz,
			logic signed [ulss_pkg::COORD_W-1:0] cx, logic signed [ulss_pkg::COORD_W-1:0] cy,
			logic signed [ulss_pkg::COORD_W-1:0] cz, logic last);
		ulss_pkg::in_item_t it;
		it.vertex_x = vx;
		it.vertex_y = vy;
		it.vertex_z = vz;
		it.corner_x = cx;
		it.corner_y = cy;
		it.corner_z = cz;
		it.last_corner = last;
		return it;
	endfunction

	// Mix of extremes, full-range values and points close to a given position.
	function automatic logic signed [ulss_pkg::COORD_W-1:0] rand_coord(
			logic signed [ulss_pkg::COORD_W-1:0] near);
		case ($urandom_range(0, 9))
			0: return C_MIN;
			1: return C_MAX;
			2, 3, 4: return $urandom;
			default: return near + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
		endcase
	endfunction

	// Offer one item; the sender runs in bursts separated by random gaps.
	task automatic send_item(input ulss_pkg::in_item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 7) == 0)
				gap = $urandom_range(13, 200);
			else
				gap = $urandom_range(0, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
				: $urandom_range(1, 8);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Drain all pending results, then let the block settle before a gain write.
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_gain(input logic signed [ulss_pkg::GAIN_W-1:0] g);
		cfg_valid <= 1'b1;
		cfg_data <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		gain_writes++;
	endtask

	// One vertex: mostly whole triangles, sometimes partial, long or noisy sequences.
	task automatic send_random_vertex(output int unsigned n);
		int unsigned kind;
		bit vary;
		bit noisy;
		bit last;
		logic signed [ulss_pkg::COORD_W-1:0] base[ulss_pkg::NUM_AXES];
		logic signed [ulss_pkg::COORD_W-1:0] v[ulss_pkg::NUM_AXES];
		logic signed [ulss_pkg::COORD_W-1:0] c[ulss_pkg::NUM_AXES];
		kind = $urandom_range(0, 99);
		vary = ($urandom_range(0, 9) == 0);
		noisy = 1'b0;
		if (kind < 70) begin
			n = 3 * $urandom_range(1, 8);
		end else if (kind < 80) begin
			n = 3 * $urandom_range(0, 6) + $urandom_range(1, 2);
		end else if (kind < 85) begin
			n = $urandom_range(1, 2);
		end else if (kind < 86) begin
			n = $urandom_range(190, 215);
		end else begin
			n = $urandom_range(2, 12);
			noisy = 1'b1;
			vary = 1'b1;
		end
		foreach (base[a])
			base[a] = rand_coord($urandom);
		for (int i = 0; i < n; i++) begin
			foreach (v[a]) begin
				v[a] = vary ? rand_coord(base[a]) : base[a];
				c[a] = rand_coord(v[a]);
			end
			last = (i == n - 1) || (noisy && $urandom_range(0, 3) == 0);
			send_item(make_item(v[0], v[1], v[2], c[0], c[1], c[2], last));
		end
	endtask

	task automatic random_phase(input int unsigned n_items);
		int unsigned done_items;
		int unsigned n;
		done_items = 0;
		while (done_items < n_items) begin
			send_random_vertex(n);
			done_items += n;
		end
	endtask

	initial begin
		logic signed [ulss_pkg::GAIN_W-1:0] gains[$];
		gains = '{16'sh8000, 16'sh0000, 16'sh0001, -16'sh0001, 16'sh4000,
			16'($urandom), 16'($urandom), ulss_pkg::GAIN_RESET};
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset gain of one half.
		// Lone closing item: no whole triangle, extreme vertex passes through.
		send_item(make_item(C_MIN, C_MAX, 0, $urandom, $urandom, $urandom, 1'b1));
		// Two corners only: still no whole triangle.
		send_item(make_item(5, 6, 7, 100, 200, 300, 1'b0));
		send_item(make_item(-5, -6, -7, 1, 2, 3, 1'b1));
		// One triangle with half-way ties in both the mean and the gain product.
		send_item(make_item(0, 0, 0, 1, -1, 0, 1'b0));
		send_item(make_item(0, 0, 0, 1, -1, 0, 1'b0));
		send_item(make_item(0, 0, 0, 1, -1, 1, 1'b1));
		// Output saturates high: large positive offsets from the earlier corners.
		repeat (2) send_item(make_item(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 1'b0));
		send_item(make_item(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1));
		// Output saturates low.
		repeat (2) send_item(make_item(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 1'b0));
		send_item(make_item(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, 1'b1));
		// Two triangles with full-range values, each item its own vertex.
		for (int i = 0; i < 6; i++)
			send_item(make_item($urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, i == 5));
		random_phase(PHASE_ITEMS);

		// Full gain with one extreme vertex: full-scale offsets and a saturated count.
		wait_idle();
		write_gain(16'sh7FFF);
		for (int i = 0; i < SAT_CORNERS; i++)
			send_item(make_item(C_MIN, C_MAX, $urandom, C_MAX, C_MIN, $urandom,
				i == SAT_CORNERS - 1));
		random_phase(PHASE_ITEMS);

		// Remaining gain settings, extremes among them.
		foreach (gains[g]) begin
			wait_idle();
			write_gain(gains[g]);
			random_phase(PHASE_ITEMS);
		end

		wait_idle();
		$display("Run covered %0d items, %0d vertices (%0d without a whole triangle), %0d gains.",
			items_sent, sb.closes, sb.empty_closes, gain_writes + 1);
		$display("Checked %0d results, %0d mismatches.", sb.results_checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
